// ===== rtl/prsi_pkg.sv =====
// prsi_pkg: shared types, operation codes and the squared color distance
// used by the palette ring swap improver. No dependencies.
package prsi_pkg;

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_SWAP = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam int RING_W = 9;
	localparam int SQ_W   = 18;
	localparam int GAIN_W = 20;

	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] first_index;
		logic [7:0] second_index;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
	} prsi_item_t;

	typedef struct packed {
		logic              status;
		logic              did_swap;
		logic [GAIN_W-1:0] gain;
		logic [7:0]        red_out;
		logic [7:0]        green_out;
		logic [7:0]        blue_out;
	} prsi_result_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD_PAIR,
		S_RD_A_NBR,
		S_RD_C_NBR,
		S_FINISH
	} prsi_state_t;

	typedef enum logic [1:0] {
		RD_PAIR,
		RD_A_NBR,
		RD_C_NBR
	} prsi_rd_sel_t;

	typedef struct packed {
		logic         capture;
		logic         rd_en;
		prsi_rd_sel_t rd_sel;
		logic         latch_ac;
		logic         acc_a;
		logic         finish;
	} prsi_cmd_t;

	typedef struct packed {
		logic swap_ok;
	} prsi_status_t;

	// sum of squared channel differences of two {r, g, b} entries
	function automatic logic [SQ_W-1:0] prsi_sqdist(input logic [23:0] x, input logic [23:0] y);
		logic [7:0]      xa;
		logic [7:0]      ya;
		logic [7:0]      mag;
		logic [15:0]     mag16;
		logic [15:0]     sq;
		logic [SQ_W-1:0] acc;
		acc = '0;
		for (int k = 0; k < 3; k++) begin
			xa    = x[8*k +: 8];
			ya    = y[8*k +: 8];
			mag   = (xa >= ya) ? (xa - ya) : (ya - xa);
			mag16 = {8'b0, mag};
			sq    = mag16 * mag16;
			acc   = acc + {{(SQ_W-16){1'b0}}, sq};
		end
		return acc;
	endfunction

endpackage

// ===== rtl/prsi_datapath.sv =====
// prsi_datapath: color table memory, ring size register, neighbor address
// logic, distance accumulators and the result register. Uses prsi_pkg.
module prsi_datapath #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [8:0]             cfg_write_data,
	input  prsi_pkg::prsi_item_t   item,
	input  prsi_pkg::prsi_cmd_t    cmd,
	output prsi_pkg::prsi_status_t status,
	output prsi_pkg::prsi_result_t result
);

	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int RW = prsi_pkg::RING_W;
	localparam int GW = prsi_pkg::GAIN_W;
	localparam int SW = prsi_pkg::SQ_W;

	logic [23:0]           mem [MAX_ENTRIES];
	logic [RW-1:0]         cfg_q;
	logic [RW-1:0]         ring_n;
	prsi_pkg::prsi_item_t  item_q;
	logic [23:0]           rd0_q;
	logic [23:0]           rd1_q;
	logic [23:0]           a_q;
	logic [23:0]           c_q;
	logic [GW-1:0]         before_q;
	logic [GW-1:0]         after_q;
	prsi_pkg::prsi_result_t result_q;
	prsi_pkg::prsi_result_t res_d;

	logic          err;
	logic          swap_ok;
	logic          do_swap;
	logic [RW-1:0] i0_w;
	logic [RW-1:0] i1_w;
	logic [RW-1:0] i0_prev;
	logic [RW-1:0] i0_next;
	logic [RW-1:0] i1_prev;
	logic [RW-1:0] i1_next;
	logic [AW-1:0] ra0;
	logic [AW-1:0] ra1;
	logic          we0;
	logic          we1;
	logic [23:0]   wd0;
	logic [GW-1:0] before_tot;
	logic [GW-1:0] after_tot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= 9'd256;
		end else if (cfg_write_en) begin
			cfg_q <= cfg_write_data;
		end
	end

	// ring size saturated to 2 .. MAX_ENTRIES
	always_comb begin
		if (cfg_q < 9'd2) begin
			ring_n = 9'd2;
		end else if (int'(cfg_q) > MAX_ENTRIES) begin
			ring_n = RW'(MAX_ENTRIES);
		end else begin
			ring_n = cfg_q;
		end
	end

	assign i0_w    = {1'b0, item_q.first_index};
	assign i1_w    = {1'b0, item_q.second_index};
	assign i0_prev = (i0_w == '0) ? (ring_n - 9'd1) : (i0_w - 9'd1);
	assign i0_next = ((i0_w + 9'd1) == ring_n) ? '0 : (i0_w + 9'd1);
	assign i1_prev = (i1_w == '0) ? (ring_n - 9'd1) : (i1_w - 9'd1);
	assign i1_next = ((i1_w + 9'd1) == ring_n) ? '0 : (i1_w + 9'd1);

	always_comb begin
		err = 1'b0;
		if (item_q.operation == prsi_pkg::OP_LOAD || item_q.operation == prsi_pkg::OP_READ) begin
			err = (i0_w >= ring_n);
		end else if (item_q.operation == prsi_pkg::OP_SWAP) begin
			err = (i0_w >= ring_n) || (i1_w >= ring_n);
		end
	end

	assign swap_ok        = (item_q.operation == prsi_pkg::OP_SWAP) && !err;
	assign status.swap_ok = swap_ok;

	always_comb begin
		case (cmd.rd_sel)
			prsi_pkg::RD_PAIR: begin
				ra0 = AW'(i0_w);
				ra1 = AW'(i1_w);
			end
			prsi_pkg::RD_A_NBR: begin
				ra0 = AW'(i0_prev);
				ra1 = AW'(i0_next);
			end
			prsi_pkg::RD_C_NBR: begin
				ra0 = AW'(i1_prev);
				ra1 = AW'(i1_next);
			end
			default: begin
				ra0 = AW'(i0_w);
				ra1 = AW'(i1_w);
			end
		endcase
	end

	// neighbors of the second entry sit in rd0_q / rd1_q while finishing
	assign before_tot = before_q
		+ {{(GW-SW){1'b0}}, prsi_pkg::prsi_sqdist(rd0_q, c_q)}
		+ {{(GW-SW){1'b0}}, prsi_pkg::prsi_sqdist(c_q, rd1_q)};
	assign after_tot = after_q
		+ {{(GW-SW){1'b0}}, prsi_pkg::prsi_sqdist(rd0_q, a_q)}
		+ {{(GW-SW){1'b0}}, prsi_pkg::prsi_sqdist(a_q, rd1_q)};
	assign do_swap = swap_ok && (after_tot < before_tot);

	assign we0 = cmd.finish && (((item_q.operation == prsi_pkg::OP_LOAD) && !err) || do_swap);
	assign we1 = cmd.finish && do_swap;
	assign wd0 = (item_q.operation == prsi_pkg::OP_LOAD)
		? {item_q.red_in, item_q.green_in, item_q.blue_in} : c_q;

	always_ff @(posedge clk) begin
		if (we0) begin
			mem[AW'(i0_w)] <= wd0;
		end
		if (we1) begin
			mem[AW'(i1_w)] <= a_q;
		end
		if (cmd.rd_en) begin
			rd0_q <= mem[ra0];
			rd1_q <= mem[ra1];
		end
	end

	always_comb begin
		res_d = '0;
		if (err) begin
			res_d.status = 1'b1;
		end else begin
			case (item_q.operation)
				prsi_pkg::OP_READ: begin
					res_d.red_out   = rd0_q[23:16];
					res_d.green_out = rd0_q[15:8];
					res_d.blue_out  = rd0_q[7:0];
				end
				prsi_pkg::OP_SWAP: begin
					res_d.did_swap = do_swap;
					res_d.gain     = do_swap ? (before_tot - after_tot) : '0;
				end
				default: begin
					res_d = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.latch_ac) begin
			a_q <= rd0_q;
			c_q <= rd1_q;
		end
		// neighbors of the first entry sit in rd0_q / rd1_q here
		if (cmd.acc_a) begin
			before_q <= {{(GW-SW){1'b0}}, prsi_pkg::prsi_sqdist(rd0_q, a_q)}
				+ {{(GW-SW){1'b0}}, prsi_pkg::prsi_sqdist(a_q, rd1_q)};
			after_q  <= {{(GW-SW){1'b0}}, prsi_pkg::prsi_sqdist(rd0_q, c_q)}
				+ {{(GW-SW){1'b0}}, prsi_pkg::prsi_sqdist(c_q, rd1_q)};
		end
		if (cmd.finish) begin
			result_q <= res_d;
		end
	end

	assign result = result_q;

endmodule

// ===== rtl/prsi_ctrl.sv =====
// prsi_ctrl: sequencer for one item at a time and the result valid flag.
// Drives datapath commands; uses prsi_pkg.
module prsi_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	output logic                   result_valid,
	input  logic                   result_ready,
	input  prsi_pkg::prsi_status_t status,
	output prsi_pkg::prsi_cmd_t    cmd
);

	prsi_pkg::prsi_state_t state_q;
	prsi_pkg::prsi_state_t state_d;
	logic                  out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= prsi_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			prsi_pkg::S_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d     = prsi_pkg::S_RD_PAIR;
				end
			end
			prsi_pkg::S_RD_PAIR: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = prsi_pkg::RD_PAIR;
				state_d    = status.swap_ok ? prsi_pkg::S_RD_A_NBR : prsi_pkg::S_FINISH;
			end
			prsi_pkg::S_RD_A_NBR: begin
				cmd.latch_ac = 1'b1;
				cmd.rd_en    = 1'b1;
				cmd.rd_sel   = prsi_pkg::RD_A_NBR;
				state_d      = prsi_pkg::S_RD_C_NBR;
			end
			prsi_pkg::S_RD_C_NBR: begin
				cmd.acc_a  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = prsi_pkg::RD_C_NBR;
				state_d    = prsi_pkg::S_FINISH;
			end
			prsi_pkg::S_FINISH: begin
				// wait for the output register to free up
				if (!out_valid_q || result_ready) begin
					cmd.finish = 1'b1;
					state_d    = prsi_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = prsi_pkg::S_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_capture_reads: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> (state_q == prsi_pkg::S_RD_PAIR))
		else $error("capture not followed by pair read");

	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> result_valid)
		else $error("finished beat not presented");

	a_acc_after_latch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_a |-> $past(cmd.latch_ac))
		else $error("accumulate without latched swap operands");

	a_finish_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == prsi_pkg::S_FINISH && !cmd.finish) |=>
		(state_q == prsi_pkg::S_FINISH && result_valid))
		else $error("stalled finish lost its place");
`endif

endmodule

// ===== rtl/palette_ring_swap_improver_top.sv =====
// palette_ring_swap_improver_top: ring palette with load, read and swap trial.
// A swap trial reads the pair, then the first entry's neighbors, then the second
// entry's neighbors from the dual-port table and finishes; load, read and errors
// go from the pair read to finish. A new item is taken only when idle again.
// Reset: ring size 256, sequencer idle, no result; table undefined until loaded.
module palette_ring_swap_improver_top #(
	parameter int MAX_ENTRIES = 256
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [8:0]             cfg_write_data,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  prsi_pkg::prsi_item_t   item,
	output logic                   result_valid,
	input  logic                   result_ready,
	output prsi_pkg::prsi_result_t result
);

	prsi_pkg::prsi_cmd_t    cmd;
	prsi_pkg::prsi_status_t status;

	prsi_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	prsi_datapath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write_en   (cfg_write_en),
		.cfg_write_data (cfg_write_data),
		.item           (item),
		.cmd            (cmd),
		.status         (status),
		.result         (result)
	);

endmodule
